// ----- hw/rtl/sps_pkg.sv -----
// Shared types and codes for the slotted page store.
package sps_pkg;

    localparam int MODE_W = 2;
    localparam int PNUM_W = 16;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 13;
    localparam int SLOT_W = 12;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_SLOT = 2'd2;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd3;

    typedef enum logic [1:0] {
        RES_STATUS = 2'd0,
        RES_COMMIT = 2'd1,
        RES_BYTE   = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic              ins_fresh;
        logic              init;
        logic              ins_first;
        logic              ins_byte;
        logic              fill_byte;
        logic              commit;
        logic              slot_rd;
        logic              get_start;
        logic              get_issue;
        logic              out_load;
        res_sel_t          out_sel;
        logic [STAT_W-1:0] out_status;
    } sps_cmd_t;

    typedef struct packed {
        logic too_long;
        logic no_space;
        logic bad_slot;
        logic fill_needed;
        logic fill_last;
        logic len_zero;
        logic get_left_nz;
        logic rd_pend;
        logic out_left_one;
        logic out_space;
    } sps_sts_t;

endpackage

// ----- hw/rtl/sps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/sps_ctrl.sv -----
// Controller state machine for page init, tuple insert and tuple get.
module sps_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [sps_pkg::MODE_W-1:0]       mode,
    input  logic                             last_byte,
    input  sps_pkg::sps_sts_t                sts,
    output sps_pkg::sps_cmd_t                cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FILL   = 4'b0010,
        S_SLOT   = 4'b0100,
        S_STREAM = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        I_IDLE = 3'b001,
        I_RECV = 3'b010,
        I_DROP = 3'b100
    } ins_state_t;

    state_t     state_reg, state_next;
    ins_state_t ins_reg, ins_next;
    logic       accept;
    logic       load_byte;

    always_comb
    begin
        cmd            = '0;
        cmd.out_sel    = sps_pkg::RES_STATUS;
        cmd.out_status = sps_pkg::ST_OK;
        cmd.ins_fresh  = (ins_reg == I_IDLE);
        state_next     = state_reg;
        ins_next       = ins_reg;
        in_stall       = !((state_reg == S_IDLE) && sts.out_space);
        accept         = in_valid && !in_stall;
        load_byte      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        sps_pkg::MODE_INIT:
                        begin
                            cmd.init     = 1'b1;
                            cmd.out_load = 1'b1;
                            ins_next     = I_IDLE;
                        end
                        sps_pkg::MODE_INSERT:
                        begin
                            if (ins_reg == I_DROP)
                            begin
                                if (last_byte)
                                begin
                                    ins_next = I_IDLE;
                                end
                            end
                            else if ((ins_reg == I_IDLE) && sts.too_long)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = sps_pkg::ST_TOO_LONG;
                                ins_next       = last_byte ? I_IDLE : I_DROP;
                            end
                            else if ((ins_reg == I_IDLE) && sts.no_space)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = sps_pkg::ST_NO_SPACE;
                                ins_next       = last_byte ? I_IDLE : I_DROP;
                            end
                            else
                            begin
                                cmd.ins_first = (ins_reg == I_IDLE);
                                cmd.ins_byte  = 1'b1;
                                ins_next      = I_RECV;
                                if (last_byte)
                                begin
                                    if (sts.fill_needed)
                                    begin
                                        state_next = S_FILL;
                                    end
                                    else
                                    begin
                                        cmd.commit   = 1'b1;
                                        cmd.out_load = 1'b1;
                                        cmd.out_sel  = sps_pkg::RES_COMMIT;
                                        ins_next     = I_IDLE;
                                    end
                                end
                            end
                        end
                        sps_pkg::MODE_GET:
                        begin
                            if (sts.bad_slot)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = sps_pkg::ST_BAD_SLOT;
                            end
                            else
                            begin
                                cmd.slot_rd = 1'b1;
                                state_next  = S_SLOT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                if (!sts.fill_last)
                begin
                    cmd.fill_byte = 1'b1;
                end
                else if (sts.out_space)
                begin
                    cmd.fill_byte = 1'b1;
                    cmd.commit    = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = sps_pkg::RES_COMMIT;
                    ins_next      = I_IDLE;
                    state_next    = S_IDLE;
                end
            end
            S_SLOT:
            begin
                if (sts.len_zero)
                begin
                    if (sts.out_space)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.get_start = 1'b1;
                    state_next    = S_STREAM;
                end
            end
            S_STREAM:
            begin
                load_byte     = sts.rd_pend && sts.out_space;
                cmd.get_issue = sts.get_left_nz && (!sts.rd_pend || load_byte);
                if (load_byte)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = sps_pkg::RES_BYTE;
                    if (sts.out_left_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ins_reg   <= I_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ins_reg   <= ins_next;
        end
    end

endmodule

// ----- hw/rtl/sps_dp.sv -----
// Datapath: page and slot memories, space bookkeeping, get stream and result register.
module sps_dp #(
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int SLOT_BYTES   = 4,
    parameter int MAX_SLOTS    = 1024,
    parameter int MAX_TUPLE    = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sps_pkg::sps_cmd_t            cmd,
    output sps_pkg::sps_sts_t            sts,
    input  logic [sps_pkg::PNUM_W-1:0]   page_number,
    input  logic [sps_pkg::BYTE_W-1:0]   data_byte,
    input  logic [sps_pkg::LEN_W-1:0]    tuple_length,
    input  logic [sps_pkg::SLOT_W-1:0]   slot_number,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [sps_pkg::STAT_W-1:0]   status,
    output logic [sps_pkg::SLOT_W-1:0]   slot_out,
    output logic [sps_pkg::BYTE_W-1:0]   byte_out,
    output logic                         byte_valid,
    output logic [sps_pkg::LEN_W-1:0]    length_out,
    output logic                         last_out
);

    localparam int LENW  = sps_pkg::LEN_W;
    localparam int SLOTW = sps_pkg::SLOT_W;
    localparam int BYTEW = sps_pkg::BYTE_W;
    localparam int AW    = $clog2(PAGE_BYTES);
    localparam int LW    = $clog2(MAX_TUPLE + 1);
    localparam int SCW   = $clog2(MAX_SLOTS + 1);
    localparam int SIW   = $clog2(MAX_SLOTS);
    localparam int CW    = (SCW > SLOTW) ? SCW : SLOTW;
    localparam int UW    = $clog2(HEADER_BYTES + MAX_SLOTS * SLOT_BYTES + PAGE_BYTES
                                  + (2 ** LENW) + SLOT_BYTES + 1);
    localparam int SEW   = AW + LW;

    logic [AW-1:0]    free_reg, free_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [AW-1:0]    get_addr_reg, get_addr_next;
    logic [SCW-1:0]   slot_count_reg, slot_count_next;
    logic [UW-1:0]    used_reg, used_next;
    logic [sps_pkg::PNUM_W-1:0] page_ident_reg, page_ident_next;
    logic [LW-1:0]    pend_len_reg, pend_len_next;
    logic [LW-1:0]    cnt_reg, cnt_next;
    logic [LW-1:0]    get_left_reg, get_left_next;
    logic [LW-1:0]    out_left_reg, out_left_next;
    logic [LW-1:0]    get_len_reg, get_len_next;
    logic             rd_pend_reg, rd_pend_next;

    logic                       out_valid_reg, out_valid_next;
    logic [sps_pkg::STAT_W-1:0] status_reg, status_next;
    logic [SLOTW-1:0]           slot_out_reg, slot_out_next;
    logic [BYTEW-1:0]           byte_out_reg, byte_out_next;
    logic                       byte_valid_reg, byte_valid_next;
    logic [LENW-1:0]            length_out_reg, length_out_next;
    logic                       last_out_reg, last_out_next;

    logic [LW-1:0]    len_eff;
    logic [LW-1:0]    cnt_eff;
    logic [AW-1:0]    ptr_eff;
    logic             room;
    logic [AW-1:0]    new_free;
    logic [UW-1:0]    need_sum;

    logic             page_we;
    logic [AW-1:0]    page_waddr;
    logic [BYTEW-1:0] page_wdata;
    logic [BYTEW-1:0] page_rdata;
    logic [SEW-1:0]   slot_wdata;
    logic [SEW-1:0]   slot_rdata;
    logic [AW-1:0]    sl_off;
    logic [LW-1:0]    sl_len;

    assign len_eff  = cmd.ins_fresh ? LW'(tuple_length) : pend_len_reg;
    assign cnt_eff  = cmd.ins_fresh ? '0 : cnt_reg;
    assign ptr_eff  = cmd.ins_fresh ? (free_reg - AW'(tuple_length)) : ptr_reg;
    assign room     = cnt_eff < len_eff;
    assign new_free = free_reg - AW'(len_eff);
    assign need_sum = used_reg + UW'(tuple_length) + UW'(SLOT_BYTES);
    assign sl_off   = slot_rdata[SEW-1:LW];
    assign sl_len   = slot_rdata[LW-1:0];

    assign sts.too_long     = tuple_length > LENW'(MAX_TUPLE);
    assign sts.no_space     = (slot_count_reg >= SCW'(MAX_SLOTS)) || (need_sum > UW'(free_reg));
    assign sts.bad_slot     = CW'(slot_number) >= CW'(slot_count_reg);
    assign sts.fill_needed  = ((LW + 1)'(cnt_eff) + (LW + 1)'(1)) < (LW + 1)'(len_eff);
    assign sts.fill_last    = ((LW + 1)'(cnt_reg) + (LW + 1)'(1)) == (LW + 1)'(pend_len_reg);
    assign sts.len_zero     = (sl_len == '0);
    assign sts.get_left_nz  = (get_left_reg != '0);
    assign sts.rd_pend      = rd_pend_reg;
    assign sts.out_left_one = (out_left_reg == LW'(1));
    assign sts.out_space    = !out_valid_reg || !out_stall;

    assign page_we    = (cmd.ins_byte && room) || cmd.fill_byte;
    assign page_waddr = cmd.fill_byte ? ptr_reg : ptr_eff;
    assign page_wdata = cmd.fill_byte ? '0 : data_byte;
    assign slot_wdata = {new_free, len_eff};

    sps_ram #(
        .WIDTH(BYTEW),
        .DEPTH(PAGE_BYTES)
    ) u_page_ram (
        .clk  (clk),
        .we   (page_we),
        .waddr(page_waddr),
        .wdata(page_wdata),
        .re   (cmd.get_issue),
        .raddr(get_addr_reg),
        .rdata(page_rdata)
    );

    sps_ram #(
        .WIDTH(SEW),
        .DEPTH(MAX_SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (cmd.commit),
        .waddr(SIW'(slot_count_reg)),
        .wdata(slot_wdata),
        .re   (cmd.slot_rd),
        .raddr(SIW'(slot_number)),
        .rdata(slot_rdata)
    );

    always_comb
    begin
        free_next       = free_reg;
        ptr_next        = ptr_reg;
        get_addr_next   = get_addr_reg;
        slot_count_next = slot_count_reg;
        used_next       = used_reg;
        page_ident_next = page_ident_reg;
        pend_len_next   = pend_len_reg;
        cnt_next        = cnt_reg;
        get_left_next   = get_left_reg;
        out_left_next   = out_left_reg;
        get_len_next    = get_len_reg;
        rd_pend_next    = rd_pend_reg;

        if (cmd.init)
        begin
            free_next       = AW'(PAGE_BYTES - 1);
            slot_count_next = '0;
            used_next       = UW'(HEADER_BYTES);
            page_ident_next = page_number;
            ptr_next        = '0;
            cnt_next        = '0;
            pend_len_next   = '0;
        end

        if (cmd.ins_first)
        begin
            pend_len_next = LW'(tuple_length);
        end

        if (cmd.ins_byte)
        begin
            if (room)
            begin
                ptr_next = ptr_eff + AW'(1);
                cnt_next = cnt_eff + LW'(1);
            end
            else
            begin
                ptr_next = ptr_eff;
                cnt_next = cnt_eff;
            end
        end

        if (cmd.fill_byte)
        begin
            ptr_next = ptr_reg + AW'(1);
            cnt_next = cnt_reg + LW'(1);
        end

        if (cmd.commit)
        begin
            free_next       = new_free;
            slot_count_next = slot_count_reg + SCW'(1);
            used_next       = used_reg + UW'(SLOT_BYTES);
        end

        if (cmd.get_start)
        begin
            get_addr_next = sl_off;
            get_left_next = sl_len;
            out_left_next = sl_len;
            get_len_next  = sl_len;
        end

        if (cmd.get_issue)
        begin
            get_addr_next = get_addr_reg + AW'(1);
            get_left_next = get_left_reg - LW'(1);
            rd_pend_next  = 1'b1;
        end
        else if (cmd.out_load && (cmd.out_sel == sps_pkg::RES_BYTE))
        begin
            rd_pend_next = 1'b0;
        end

        if (cmd.out_load && (cmd.out_sel == sps_pkg::RES_BYTE))
        begin
            out_left_next = out_left_reg - LW'(1);
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        slot_out_next   = slot_out_reg;
        byte_out_next   = byte_out_reg;
        byte_valid_next = byte_valid_reg;
        length_out_next = length_out_reg;
        last_out_next   = last_out_reg;

        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            status_next     = cmd.out_status;
            slot_out_next   = '0;
            byte_out_next   = '0;
            byte_valid_next = 1'b0;
            length_out_next = '0;
            last_out_next   = 1'b1;
            case (cmd.out_sel)
                sps_pkg::RES_COMMIT:
                begin
                    status_next   = sps_pkg::ST_OK;
                    slot_out_next = SLOTW'(slot_count_reg);
                end
                sps_pkg::RES_BYTE:
                begin
                    status_next     = sps_pkg::ST_OK;
                    byte_out_next   = page_rdata;
                    byte_valid_next = 1'b1;
                    length_out_next = LENW'(get_len_reg);
                    last_out_next   = (out_left_reg == LW'(1));
                end
                default:
                begin
                end
            endcase
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg       <= AW'(PAGE_BYTES - 1);
            ptr_reg        <= '0;
            get_addr_reg   <= '0;
            slot_count_reg <= '0;
            used_reg       <= UW'(HEADER_BYTES);
            page_ident_reg <= '0;
            pend_len_reg   <= '0;
            cnt_reg        <= '0;
            get_left_reg   <= '0;
            out_left_reg   <= '0;
            get_len_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            free_reg       <= free_next;
            ptr_reg        <= ptr_next;
            get_addr_reg   <= get_addr_next;
            slot_count_reg <= slot_count_next;
            used_reg       <= used_next;
            page_ident_reg <= page_ident_next;
            pend_len_reg   <= pend_len_next;
            cnt_reg        <= cnt_next;
            get_left_reg   <= get_left_next;
            out_left_reg   <= out_left_next;
            get_len_reg    <= get_len_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        slot_out_reg   <= slot_out_next;
        byte_out_reg   <= byte_out_next;
        byte_valid_reg <= byte_valid_next;
        length_out_reg <= length_out_next;
        last_out_reg   <= last_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_out   = slot_out_reg;
    assign byte_out   = byte_out_reg;
    assign byte_valid = byte_valid_reg;
    assign length_out = length_out_reg;
    assign last_out   = last_out_reg;

endmodule

// ----- hw/rtl/slotted_page_store_unit.sv -----
// Top level: slotted page store with controller, datapath and assertions.
// Insert bytes are taken one per cycle unless the output is held; init, a reject or a closing
// byte with no fill due gives its result in the next cycle. A tuple closed short is zero-filled
// to length in page memory, then committed. Get: a slot-table read, an address load, a page read,
// then a byte a cycle unless held. Input stalls in a fill, slot read, get stream or output hold.
// rst_n (async) clears control, counts and page header; the memories keep contents, no clear pass.
module slotted_page_store_unit #(
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int SLOT_BYTES   = 4,
    parameter int MAX_SLOTS    = 1024,
    parameter int MAX_TUPLE    = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sps_pkg::MODE_W-1:0]   mode,
    input  logic [sps_pkg::PNUM_W-1:0]   page_number,
    input  logic [sps_pkg::BYTE_W-1:0]   data_byte,
    input  logic [sps_pkg::LEN_W-1:0]    tuple_length,
    input  logic                         last_byte,
    input  logic [sps_pkg::SLOT_W-1:0]   slot_number,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sps_pkg::STAT_W-1:0]   status,
    output logic [sps_pkg::SLOT_W-1:0]   slot_out,
    output logic [sps_pkg::BYTE_W-1:0]   byte_out,
    output logic                         byte_valid,
    output logic [sps_pkg::LEN_W-1:0]    length_out,
    output logic                         last_out
);

    sps_pkg::sps_cmd_t cmd;
    sps_pkg::sps_sts_t sts;

    sps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .last_byte(last_byte),
        .sts      (sts),
        .cmd      (cmd)
    );

    sps_dp #(
        .PAGE_BYTES  (PAGE_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .SLOT_BYTES  (SLOT_BYTES),
        .MAX_SLOTS   (MAX_SLOTS),
        .MAX_TUPLE   (MAX_TUPLE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .page_number (page_number),
        .data_byte   (data_byte),
        .tuple_length(tuple_length),
        .slot_number (slot_number),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status      (status),
        .slot_out    (slot_out),
        .byte_out    (byte_out),
        .byte_valid  (byte_valid),
        .length_out  (length_out),
        .last_out    (last_out)
    );

    a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result loaded over a held transfer");

    a_page_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.get_issue |-> !(cmd.ins_byte || cmd.fill_byte))
        else $error("page memory read and write in one cycle");

    a_bad_slot_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (mode == sps_pkg::MODE_GET) && sts.bad_slot)
        |=> (out_valid && (status == sps_pkg::ST_BAD_SLOT) && last_out))
        else $error("bad slot get gave no bad slot result");

    a_byte_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (length_out != '0))
        else $error("tuple byte with zero length");

endmodule
